// ===== rtl/core/s2c_pkg.sv =====
// ----------------------------------------------------------------------------
// s2c_pkg: shared types and constants for the spherical to Cartesian block
// Field widths, CORDIC formats, the arctangent table and the lane structure
// that travels down the chain of rotation cells.
// ----------------------------------------------------------------------------
package s2c_pkg;

  localparam int RADIUS_BITS  = 16;
  localparam int ANGLE_BITS   = 16;
  localparam int OUT_BITS     = RADIUS_BITS + 1;

  // Rotation datapath: Q1.15 sine and cosine, 32-bit phase residual.
  localparam int CORDIC_STEPS = 15;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int CW           = 18;
  localparam int ZW           = 32;
  localparam int SC_W         = 16;
  localparam int PROD_W       = 2 * SC_W;
  localparam int FRAC_XY      = 2 * (SC_W - 1);
  localparam int FRAC_Z       = SC_W - 1;
  localparam int XY_W         = RADIUS_BITS + 1 + PROD_W;
  localparam int ZP_W         = RADIUS_BITS + 1 + SC_W;

  // Gain-compensated 1.0 in Q1.15.
  localparam logic signed [CW-1:0] CORDIC_X0 = CW'(19899);

  // Arctangent of 2^-i in units of 2^-32 turn.
  localparam logic [ZW-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA
  };

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 flip;
  } rot_t;

  typedef struct packed {
    logic [RADIUS_BITS-1:0] radius;
    rot_t                   zen;
    rot_t                   azi;
  } lane_t;

endpackage

// ===== rtl/core/s2c_prep.sv =====
// ----------------------------------------------------------------------------
// s2c_prep: angle folding stage
// Turns each binary angle into a residual within a quarter turn of zero,
// marks the angles that were moved by a half turn, and seeds the rotators.
// ----------------------------------------------------------------------------
module s2c_prep import s2c_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [RADIUS_BITS-1:0] radius,
  input  logic [ANGLE_BITS-1:0]  zenith_angle,
  input  logic [ANGLE_BITS-1:0]  azimuth_angle,
  output logic                   out_valid,
  output lane_t                  out_lane
);

  function automatic rot_t fold(input logic [ANGLE_BITS-1:0] angle);
    logic [ZW-1:0] phase;
    rot_t          r;
    phase  = {angle, {(ZW-ANGLE_BITS){1'b0}}};
    r.flip = phase[ZW-1] ^ phase[ZW-2];
    // Adding a half turn only toggles the top bit of the phase.
    r.z    = $signed({phase[ZW-1] ^ r.flip, phase[ZW-2:0]});
    r.x    = CORDIC_X0;
    r.y    = '0;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_lane.radius <= radius;
      out_lane.zen    <= fold(zenith_angle);
      out_lane.azi    <= fold(azimuth_angle);
    end
  end

  // The folded residual always lies within a quarter turn of zero.
  a_zen_folded: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_lane.zen.z[ZW-1] == out_lane.zen.z[ZW-2]))
    else $error("zenith residual outside a quarter turn");
  a_azi_folded: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_lane.azi.z[ZW-1] == out_lane.azi.z[ZW-2]))
    else $error("azimuth residual outside a quarter turn");
  a_seed: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_lane.zen.x == CORDIC_X0 && out_lane.azi.y == '0))
    else $error("rotator seed corrupted");

endmodule

// ===== rtl/core/s2c_cell.sv =====
// ----------------------------------------------------------------------------
// s2c_cell: one CORDIC rotation step
// Applies one micro-rotation to both the zenith and the azimuth rotator and
// hands the lane to the next cell. The step input is tied to a constant.
// ----------------------------------------------------------------------------
module s2c_cell import s2c_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic [STEP_W-1:0] step,
  input  logic              in_valid,
  input  lane_t             in_lane,
  output logic              out_valid,
  output lane_t             out_lane
);

  function automatic rot_t rotate(input rot_t r, input logic [STEP_W-1:0] i);
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [ZW-1:0] a;
    rot_t                 n;
    dx = r.y >>> i;
    dy = r.x >>> i;
    a  = $signed(ATAN_TURNS[i]);
    n  = r;
    if (!r.z[ZW-1]) begin
      n.x = r.x - dx;
      n.y = r.y + dy;
      n.z = r.z - a;
    end else begin
      n.x = r.x + dx;
      n.y = r.y - dy;
      n.z = r.z + a;
    end
    return n;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_lane.radius <= in_lane.radius;
      out_lane.zen    <= rotate(in_lane.zen, step);
      out_lane.azi    <= rotate(in_lane.azi, step);
    end
  end

endmodule

// ===== rtl/core/s2c_scale.sv =====
// ----------------------------------------------------------------------------
// s2c_scale: unfold, multiply and round
// Restores the sign of folded angles, saturates sine and cosine to Q1.15,
// forms the sine-cosine products, scales by the radius and rounds.
// ----------------------------------------------------------------------------
module s2c_scale import s2c_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  lane_t                      in_lane,
  output logic                       out_valid,
  output logic signed [OUT_BITS-1:0] x_coord,
  output logic signed [OUT_BITS-1:0] y_coord,
  output logic signed [OUT_BITS-1:0] z_coord
);

  localparam logic signed [XY_W-1:0] LIM_XY = XY_W'({1'b0, {RADIUS_BITS{1'b1}}});
  localparam logic signed [ZP_W-1:0] LIM_Z  = ZP_W'({1'b0, {RADIUS_BITS{1'b1}}});
  localparam logic signed [XY_W-1:0] RND_XY = XY_W'(1) <<< (FRAC_XY - 1);
  localparam logic signed [ZP_W-1:0] RND_Z  = ZP_W'(1) <<< (FRAC_Z - 1);
  localparam logic signed [CW-1:0]   SC_MAX = CW'({1'b0, {(SC_W-1){1'b1}}});
  localparam logic signed [CW-1:0]   SC_MIN = -SC_MAX - CW'(1);
  localparam logic [OUT_BITS-1:0]    OUT_MIN = {1'b1, {RADIUS_BITS{1'b0}}};

  function automatic logic signed [SC_W-1:0] unfold(input logic signed [CW-1:0] v,
                                                     input logic flip);
    logic signed [CW-1:0] s;
    s = flip ? -v : v;
    priority if (s > SC_MAX) return SC_W'(SC_MAX);
    else if (s < SC_MIN)     return SC_W'(SC_MIN);
    else                     return s[SC_W-1:0];
  endfunction

  function automatic logic signed [OUT_BITS-1:0] sat_xy(input logic signed [XY_W-1:0] p);
    logic signed [XY_W-1:0] v;
    v = (p + RND_XY) >>> FRAC_XY;
    priority if (v > LIM_XY) return OUT_BITS'(LIM_XY);
    else if (v < -LIM_XY)    return OUT_BITS'(-LIM_XY);
    else                     return v[OUT_BITS-1:0];
  endfunction

  function automatic logic signed [OUT_BITS-1:0] sat_z(input logic signed [ZP_W-1:0] p);
    logic signed [ZP_W-1:0] v;
    v = (p + RND_Z) >>> FRAC_Z;
    priority if (v > LIM_Z) return OUT_BITS'(LIM_Z);
    else if (v < -LIM_Z)    return OUT_BITS'(-LIM_Z);
    else                    return v[OUT_BITS-1:0];
  endfunction

  // Stage 1: unfolded sine and cosine.
  logic                   v1;
  logic [RADIUS_BITS-1:0] r1;
  logic signed [SC_W-1:0] st, ct, sp, cp;
  // Stage 2: sine-cosine products.
  logic                   v2;
  logic [RADIUS_BITS-1:0] r2;
  logic signed [PROD_W-1:0] pc, ps;
  logic signed [SC_W-1:0] ct2;
  // Stage 3: radius-scaled values.
  logic                   v3;
  logic signed [XY_W-1:0] px, py;
  logic signed [ZP_W-1:0] pz;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1      <= in_lane.radius;
      st      <= unfold(in_lane.zen.y, in_lane.zen.flip);
      ct      <= unfold(in_lane.zen.x, in_lane.zen.flip);
      sp      <= unfold(in_lane.azi.y, in_lane.azi.flip);
      cp      <= unfold(in_lane.azi.x, in_lane.azi.flip);
      r2      <= r1;
      pc      <= st * cp;
      ps      <= st * sp;
      ct2     <= ct;
      px      <= $signed({1'b0, r2}) * pc;
      py      <= $signed({1'b0, r2}) * ps;
      pz      <= $signed({1'b0, r2}) * ct2;
      x_coord <= sat_xy(px);
      y_coord <= sat_xy(py);
      z_coord <= sat_z(pz);
    end
  end

  // Saturation never lets the most negative code through.
  a_x_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (x_coord != OUT_MIN))
    else $error("x_coord outside the symmetric range");
  a_y_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (y_coord != OUT_MIN))
    else $error("y_coord outside the symmetric range");
  a_z_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (z_coord != OUT_MIN))
    else $error("z_coord outside the symmetric range");

endmodule

// ===== rtl/core/spherical_to_cartesian_top.sv =====
// From an input transfer to out_valid a lane passes the fold stage, 15 CORDIC
// cells, unfold, two multiply stages and the rounding output register.
// Throughput: one item per cycle, set by the chain of rotation cells, each of
// which holds one item; the whole chain holds while a result waits on out_ready.
// Reset clears every valid bit in the chain; the datapath registers are not reset.
// ----------------------------------------------------------------------------
// spherical_to_cartesian_top: spherical to Cartesian coordinate converter
// Computes r*sin(theta)*cos(phi), r*sin(theta)*sin(phi) and r*cos(theta)
// with a pipelined CORDIC whose cells rotate both angles side by side.
// ----------------------------------------------------------------------------
module spherical_to_cartesian_top import s2c_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [RADIUS_BITS-1:0]     radius,
  input  logic [ANGLE_BITS-1:0]      zenith_angle,
  input  logic [ANGLE_BITS-1:0]      azimuth_angle,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [OUT_BITS-1:0] x_coord,
  output logic signed [OUT_BITS-1:0] y_coord,
  output logic signed [OUT_BITS-1:0] z_coord
);

  logic  en;
  logic  vchain [CORDIC_STEPS+1];
  lane_t lchain [CORDIC_STEPS+1];

  // The pipeline advances unless a finished result is waiting for a transfer.
  assign en       = !(out_valid && !out_ready);
  assign in_ready = en;

  s2c_prep u_prep (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .in_valid      (in_valid),
    .radius        (radius),
    .zenith_angle  (zenith_angle),
    .azimuth_angle (azimuth_angle),
    .out_valid     (vchain[0]),
    .out_lane      (lchain[0])
  );

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    s2c_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .step      (STEP_W'(i)),
      .in_valid  (vchain[i]),
      .in_lane   (lchain[i]),
      .out_valid (vchain[i+1]),
      .out_lane  (lchain[i+1])
    );
  end

  s2c_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vchain[CORDIC_STEPS]),
    .in_lane   (lchain[CORDIC_STEPS]),
    .out_valid (out_valid),
    .x_coord   (x_coord),
    .y_coord   (y_coord),
    .z_coord   (z_coord)
  );

endmodule
